FILE: hdl/imq_pkg.sv
// Package for the indexed min-heap queue: widths, mode and status codes,
// and the store command/read structs. Depends on nothing.
package imq_pkg;

    localparam int HW = 9;
    localparam int KW = 32;
    localparam int PW = 32;
    localparam int CAPACITY = 256;

    typedef logic [HW-1:0]        hnd_t;
    typedef logic signed [KW-1:0] key_t;
    typedef logic [PW-1:0]        pay_t;
    typedef logic [2:0]           code_t;

    localparam hnd_t CAP_H  = hnd_t'(CAPACITY);
    localparam hnd_t ROOT_H = hnd_t'(1);
    localparam hnd_t ONE_H  = hnd_t'(1);
    localparam hnd_t ZERO_H = hnd_t'(0);
    localparam key_t KEY_MAX = key_t'(32'h7FFF_FFFF);

    localparam code_t MODE_INSERT   = 3'd0;
    localparam code_t MODE_EXTRACT  = 3'd1;
    localparam code_t MODE_REMOVE   = 3'd2;
    localparam code_t MODE_DECREASE = 3'd3;
    localparam code_t MODE_RELABEL  = 3'd4;
    localparam code_t MODE_READ     = 3'd5;

    localparam code_t ST_OK          = 3'd0;
    localparam code_t ST_EMPTY       = 3'd1;
    localparam code_t ST_FULL        = 3'd2;
    localparam code_t ST_NOT_PRESENT = 3'd3;
    localparam code_t ST_REJECTED    = 3'd4;

    typedef struct packed {
        logic p2h_we;
        hnd_t p2h_wa;
        hnd_t p2h_wd;
        hnd_t p2h_ra;
        logic h2p_we;
        hnd_t h2p_wa;
        hnd_t h2p_wd;
        hnd_t h2p_ra;
        logic key_we;
        hnd_t key_wa;
        key_t key_wd;
        hnd_t key_ra;
        logic pay_we;
        hnd_t pay_wa;
        pay_t pay_wd;
        hnd_t pay_ra;
    } store_cmd_t;

    typedef struct packed {
        hnd_t p2h;
        hnd_t h2p;
        key_t key;
        pay_t pay;
    } store_rd_t;

endpackage

FILE: hdl/imq_cmd_if.sv
// Command channel of the indexed min-heap queue.
// Depends on imq_pkg.
interface imq_cmd_if;
    logic               valid;
    logic               ready;
    imq_pkg::code_t     mode;
    imq_pkg::hnd_t      entry_handle;
    imq_pkg::key_t      key_in;
    imq_pkg::pay_t      payload_in;

    modport source (output valid, mode, entry_handle, key_in, payload_in, input ready);
    modport sink   (input valid, mode, entry_handle, key_in, payload_in, output ready);
endinterface

FILE: hdl/imq_res_if.sv
// Result channel of the indexed min-heap queue.
// Depends on imq_pkg.
interface imq_res_if;
    logic               valid;
    logic               ready;
    imq_pkg::code_t     status;
    imq_pkg::hnd_t      handle_out;
    imq_pkg::key_t      key_out;
    imq_pkg::pay_t      payload_out;
    imq_pkg::hnd_t      count;

    modport source (output valid, status, handle_out, key_out, payload_out, count,
                    input ready);
    modport sink   (input valid, status, handle_out, key_out, payload_out, count,
                    output ready);
endinterface

FILE: hdl/imq_store.sv
// Heap storage: keys, payloads and the two position/handle maps, one write
// and one registered read per memory per cycle. Depends on imq_pkg.
module imq_store (
    input  logic                clk,
    input  imq_pkg::store_cmd_t cmd,
    output imq_pkg::store_rd_t  rd
);
    import imq_pkg::*;

    hnd_t p2h_mem [CAPACITY+1];
    hnd_t h2p_mem [CAPACITY+1];
    key_t key_mem [CAPACITY+1];
    pay_t pay_mem [CAPACITY+1];

    always_ff @(posedge clk)
    begin
        if (cmd.p2h_we)
        begin
            p2h_mem[cmd.p2h_wa] <= cmd.p2h_wd;
        end
        rd.p2h <= p2h_mem[cmd.p2h_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.h2p_we)
        begin
            h2p_mem[cmd.h2p_wa] <= cmd.h2p_wd;
        end
        rd.h2p <= h2p_mem[cmd.h2p_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_we)
        begin
            key_mem[cmd.key_wa] <= cmd.key_wd;
        end
        rd.key <= key_mem[cmd.key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pay_we)
        begin
            pay_mem[cmd.pay_wa] <= cmd.pay_wd;
        end
        rd.pay <= pay_mem[cmd.pay_ra];
    end

endmodule

FILE: hdl/indexed_min_heap_queue.sv
// Channel  | dir | payload
// cmd      | in  | mode, entry_handle, key_in, payload_in
// res      | out | status, handle_out, key_out, payload_out, count
//
// After reset a sweep loads every store address, 0 through CAPACITY; cmd.ready stays low.
// One item at a time: a failed or read item goes from dispatch to the result;
// insert and decrease lift the entry level by level toward the root; extract
// moves the last entry to the root and sifts it down level by level.
// Cycles are set by the single read port per memory and the one comparator.
// A result waits in the output register; the next item is taken meanwhile.
// Top level of the indexed min-heap queue. Depends on imq_pkg, imq_store and
// the two channel interfaces.
module indexed_min_heap_queue (
    input  logic     clk,
    input  logic     rst_n,
    imq_cmd_if.sink  cmd,
    imq_res_if.source res
);
    import imq_pkg::*;

    typedef enum logic [18:0] {
        S_CLEAR    = 19'h00001,
        S_IDLE     = 19'h00002,
        S_DISPATCH = 19'h00004,
        S_EX_RD    = 19'h00008,
        S_RM_RD    = 19'h00010,
        S_DROP1    = 19'h00020,
        S_DROP2    = 19'h00040,
        S_LOADK    = 19'h00080,
        S_LIFT     = 19'h00100,
        S_LIFT_K   = 19'h00200,
        S_LIFT_C   = 19'h00400,
        S_LIFT_END = 19'h00800,
        S_SIFT     = 19'h01000,
        S_SIFT_L   = 19'h02000,
        S_SIFT_R   = 19'h04000,
        S_SIFT_RC  = 19'h08000,
        S_SIFT_C   = 19'h10000,
        S_SIFT_END = 19'h20000,
        S_RESP     = 19'h40000
    } state_t;

    state_t st_reg, st_next;
    hnd_t clr_reg, clr_next;
    hnd_t fill_reg, fill_next;
    logic rv_reg, rv_next;

    code_t mode_reg, mode_next;
    hnd_t  h_reg, h_next;
    logic  hok_reg, hok_next;
    key_t  k_reg, k_next;
    pay_t  pay_reg, pay_next;
    hnd_t  pos_reg, pos_next;
    hnd_t  mh_reg, mh_next;
    key_t  mk_reg, mk_next;
    hnd_t  selh_reg, selh_next;
    key_t  selk_reg, selk_next;
    hnd_t  rh_reg, rh_next;
    hnd_t  c_reg, c_next;
    hnd_t  last_reg, last_next;
    hnd_t  dh_reg, dh_next;
    logic  moved_reg, moved_next;
    logic  relab_reg, relab_next;
    code_t status_reg, status_next;
    hnd_t  hout_reg, hout_next;
    key_t  kout_reg, kout_next;
    pay_t  pout_reg, pout_next;

    code_t ostat_reg, ostat_next;
    hnd_t  ohnd_reg, ohnd_next;
    key_t  okey_reg, okey_next;
    pay_t  opay_reg, opay_next;
    hnd_t  ocnt_reg, ocnt_next;

    store_cmd_t sc;
    store_rd_t  rd;
    key_t cmp_a, cmp_b;
    logic gt;
    logic present;
    logic in_ok;
    hnd_t in_idx;
    hnd_t c_plus;

    imq_store u_store (
        .clk (clk),
        .cmd (sc),
        .rd  (rd)
    );

    assign gt      = cmp_a > cmp_b;
    assign in_ok   = (cmd.entry_handle != ZERO_H) && (cmd.entry_handle <= CAP_H);
    assign in_idx  = in_ok ? cmd.entry_handle : ZERO_H;
    assign present = hok_reg && (rd.h2p <= fill_reg);
    assign c_plus  = c_reg + ONE_H;

    assign cmd.ready       = (st_reg == S_IDLE);
    assign res.valid       = rv_reg;
    assign res.status      = ostat_reg;
    assign res.handle_out  = ohnd_reg;
    assign res.key_out     = okey_reg;
    assign res.payload_out = opay_reg;
    assign res.count       = ocnt_reg;

    always_comb
    begin
        st_next     = st_reg;
        clr_next    = clr_reg;
        fill_next   = fill_reg;
        rv_next     = rv_reg && !res.ready;
        mode_next   = mode_reg;
        h_next      = h_reg;
        hok_next    = hok_reg;
        k_next      = k_reg;
        pay_next    = pay_reg;
        pos_next    = pos_reg;
        mh_next     = mh_reg;
        mk_next     = mk_reg;
        selh_next   = selh_reg;
        selk_next   = selk_reg;
        rh_next     = rh_reg;
        c_next      = c_reg;
        last_next   = last_reg;
        dh_next     = dh_reg;
        moved_next  = moved_reg;
        relab_next  = relab_reg;
        status_next = status_reg;
        hout_next   = hout_reg;
        kout_next   = kout_reg;
        pout_next   = pout_reg;
        ostat_next  = ostat_reg;
        ohnd_next   = ohnd_reg;
        okey_next   = okey_reg;
        opay_next   = opay_reg;
        ocnt_next   = ocnt_reg;
        sc          = '0;
        cmp_a       = mk_reg;
        cmp_b       = rd.key;

        case (st_reg)
            S_CLEAR:
            begin
                sc.p2h_we = 1'b1;
                sc.p2h_wa = clr_reg;
                sc.p2h_wd = clr_reg;
                sc.h2p_we = 1'b1;
                sc.h2p_wa = clr_reg;
                sc.h2p_wd = clr_reg;
                sc.key_we = 1'b1;
                sc.key_wa = clr_reg;
                sc.key_wd = KEY_MAX;
                sc.pay_we = 1'b1;
                sc.pay_wa = clr_reg;
                sc.pay_wd = '0;
                clr_next  = clr_reg + ONE_H;
                if (clr_reg == CAP_H)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sc.h2p_ra = in_idx;
                sc.key_ra = in_idx;
                sc.pay_ra = in_idx;
                if (cmd.mode == MODE_INSERT)
                begin
                    sc.p2h_ra = (fill_reg < CAP_H) ? fill_reg + ONE_H : ZERO_H;
                end
                else
                begin
                    sc.p2h_ra = ROOT_H;
                end
                if (cmd.valid)
                begin
                    mode_next   = cmd.mode;
                    h_next      = cmd.entry_handle;
                    hok_next    = in_ok;
                    k_next      = cmd.key_in;
                    pay_next    = cmd.payload_in;
                    status_next = ST_OK;
                    hout_next   = '0;
                    kout_next   = '0;
                    pout_next   = '0;
                    moved_next  = 1'b0;
                    relab_next  = 1'b0;
                    st_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                st_next = S_RESP;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (fill_reg >= CAP_H)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            hout_next = rd.p2h;
                            fill_next = fill_reg + ONE_H;
                            sc.key_we = 1'b1;
                            sc.key_wa = rd.p2h;
                            sc.key_wd = k_reg;
                            sc.pay_we = 1'b1;
                            sc.pay_wa = rd.p2h;
                            sc.pay_wd = pay_reg;
                            pos_next  = fill_reg + ONE_H;
                            mh_next   = rd.p2h;
                            mk_next   = k_reg;
                            st_next   = S_LIFT;
                        end
                    end
                    MODE_EXTRACT:
                    begin
                        if (fill_reg == ZERO_H)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            hout_next = rd.p2h;
                            dh_next   = rd.p2h;
                            sc.key_ra = rd.p2h;
                            sc.pay_ra = rd.p2h;
                            sc.p2h_ra = fill_reg;
                            pos_next  = ROOT_H;
                            st_next   = S_EX_RD;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!present)
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                        else
                        begin
                            pos_next  = rd.h2p;
                            dh_next   = h_reg;
                            sc.p2h_ra = fill_reg;
                            st_next   = S_RM_RD;
                        end
                    end
                    MODE_DECREASE:
                    begin
                        cmp_a = k_reg;
                        cmp_b = rd.key;
                        if (!present)
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                        else if (gt)
                        begin
                            status_next = ST_REJECTED;
                        end
                        else
                        begin
                            sc.key_we = 1'b1;
                            sc.key_wa = h_reg;
                            sc.key_wd = k_reg;
                            pos_next  = rd.h2p;
                            mh_next   = h_reg;
                            mk_next   = k_reg;
                            st_next   = S_LIFT;
                        end
                    end
                    MODE_RELABEL:
                    begin
                        if (!present)
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                        else
                        begin
                            sc.key_we  = 1'b1;
                            sc.key_wa  = h_reg;
                            sc.key_wd  = k_reg;
                            pos_next   = rd.h2p;
                            mh_next    = h_reg;
                            mk_next    = k_reg;
                            relab_next = 1'b1;
                            st_next    = S_LIFT;
                        end
                    end
                    MODE_READ:
                    begin
                        if (!present)
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                        else
                        begin
                            kout_next = rd.key;
                            pout_next = rd.pay;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_EX_RD:
            begin
                kout_next = rd.key;
                pout_next = rd.pay;
                last_next = rd.p2h;
                st_next   = S_DROP1;
            end
            S_RM_RD:
            begin
                last_next = rd.p2h;
                st_next   = S_DROP1;
            end
            S_DROP1:
            begin
                sc.p2h_we = 1'b1;
                sc.p2h_wa = pos_reg;
                sc.p2h_wd = last_reg;
                sc.h2p_we = 1'b1;
                sc.h2p_wa = last_reg;
                sc.h2p_wd = pos_reg;
                sc.key_we = 1'b1;
                sc.key_wa = dh_reg;
                sc.key_wd = KEY_MAX;
                sc.pay_we = (mode_reg == MODE_EXTRACT);
                sc.pay_wa = dh_reg;
                sc.pay_wd = '0;
                st_next   = S_DROP2;
            end
            S_DROP2:
            begin
                sc.p2h_we = 1'b1;
                sc.p2h_wa = fill_reg;
                sc.p2h_wd = dh_reg;
                sc.h2p_we = 1'b1;
                sc.h2p_wa = dh_reg;
                sc.h2p_wd = fill_reg;
                sc.key_ra = last_reg;
                fill_next = fill_reg - ONE_H;
                mh_next   = last_reg;
                if (mode_reg == MODE_EXTRACT)
                begin
                    st_next = (fill_reg > ONE_H) ? S_LOADK : S_RESP;
                end
                else if (pos_reg == fill_reg)
                begin
                    st_next = S_RESP;
                end
                else
                begin
                    relab_next = 1'b1;
                    st_next    = S_LOADK;
                end
            end
            S_LOADK:
            begin
                mk_next = rd.key;
                st_next = (mode_reg == MODE_EXTRACT) ? S_SIFT : S_LIFT;
            end
            S_LIFT:
            begin
                sc.p2h_ra = pos_reg >> 1;
                st_next   = (pos_reg > ROOT_H) ? S_LIFT_K : S_LIFT_END;
            end
            S_LIFT_K:
            begin
                selh_next = rd.p2h;
                sc.key_ra = rd.p2h;
                st_next   = S_LIFT_C;
            end
            S_LIFT_C:
            begin
                cmp_a = rd.key;
                cmp_b = mk_reg;
                if (gt)
                begin
                    sc.p2h_we  = 1'b1;
                    sc.p2h_wa  = pos_reg;
                    sc.p2h_wd  = selh_reg;
                    sc.h2p_we  = 1'b1;
                    sc.h2p_wa  = selh_reg;
                    sc.h2p_wd  = pos_reg;
                    pos_next   = pos_reg >> 1;
                    moved_next = 1'b1;
                    st_next    = S_LIFT;
                end
                else
                begin
                    st_next = S_LIFT_END;
                end
            end
            S_LIFT_END:
            begin
                sc.p2h_we = 1'b1;
                sc.p2h_wa = pos_reg;
                sc.p2h_wd = mh_reg;
                sc.h2p_we = 1'b1;
                sc.h2p_wa = mh_reg;
                sc.h2p_wd = pos_reg;
                st_next   = (relab_reg && !moved_reg) ? S_SIFT : S_RESP;
            end
            S_SIFT:
            begin
                sc.p2h_ra = {pos_reg[HW-2:0], 1'b0};
                c_next    = {pos_reg[HW-2:0], 1'b0};
                st_next   = (pos_reg <= (fill_reg >> 1)) ? S_SIFT_L : S_SIFT_END;
            end
            S_SIFT_L:
            begin
                selh_next = rd.p2h;
                sc.key_ra = rd.p2h;
                sc.p2h_ra = (c_plus <= fill_reg) ? c_plus : ZERO_H;
                st_next   = S_SIFT_R;
            end
            S_SIFT_R:
            begin
                selk_next = rd.key;
                rh_next   = rd.p2h;
                sc.key_ra = rd.p2h;
                st_next   = (c_plus <= fill_reg) ? S_SIFT_RC : S_SIFT_C;
            end
            S_SIFT_RC:
            begin
                cmp_a = selk_reg;
                cmp_b = rd.key;
                if (gt)
                begin
                    selh_next = rh_reg;
                    selk_next = rd.key;
                    c_next    = c_plus;
                end
                st_next = S_SIFT_C;
            end
            S_SIFT_C:
            begin
                cmp_a = mk_reg;
                cmp_b = selk_reg;
                if (gt)
                begin
                    sc.p2h_we = 1'b1;
                    sc.p2h_wa = pos_reg;
                    sc.p2h_wd = selh_reg;
                    sc.h2p_we = 1'b1;
                    sc.h2p_wa = selh_reg;
                    sc.h2p_wd = pos_reg;
                    pos_next  = c_reg;
                    st_next   = S_SIFT;
                end
                else
                begin
                    st_next = S_SIFT_END;
                end
            end
            S_SIFT_END:
            begin
                sc.p2h_we = 1'b1;
                sc.p2h_wa = pos_reg;
                sc.p2h_wd = mh_reg;
                sc.h2p_we = 1'b1;
                sc.h2p_wa = mh_reg;
                sc.h2p_wd = pos_reg;
                st_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!rv_reg || res.ready)
                begin
                    rv_next    = 1'b1;
                    ostat_next = status_reg;
                    ohnd_next  = hout_reg;
                    okey_next  = kout_reg;
                    opay_next  = pout_reg;
                    ocnt_next  = fill_reg;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLEAR;
            clr_reg  <= '0;
            fill_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            fill_reg <= fill_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        h_reg      <= h_next;
        hok_reg    <= hok_next;
        k_reg      <= k_next;
        pay_reg    <= pay_next;
        pos_reg    <= pos_next;
        mh_reg     <= mh_next;
        mk_reg     <= mk_next;
        selh_reg   <= selh_next;
        selk_reg   <= selk_next;
        rh_reg     <= rh_next;
        c_reg      <= c_next;
        last_reg   <= last_next;
        dh_reg     <= dh_next;
        moved_reg  <= moved_next;
        relab_reg  <= relab_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
        kout_reg   <= kout_next;
        pout_reg   <= pout_next;
        ostat_reg  <= ostat_next;
        ohnd_reg   <= ohnd_next;
        okey_reg   <= okey_next;
        opay_reg   <= opay_next;
        ocnt_reg   <= ocnt_next;
    end

endmodule

FILE: hdl/imq_checker.sv
// Port-level checks for the indexed min-heap queue, bound to the top level.
// Depends on imq_pkg and indexed_min_heap_queue.
module imq_port_checks (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input imq_pkg::code_t status,
    input imq_pkg::hnd_t  handle_out,
    input imq_pkg::hnd_t  count
);
    import imq_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(count))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while busy");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_EMPTY |-> count == ZERO_H)
        else $error("empty status with entries");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_FULL |-> count == CAP_H)
        else $error("full status below capacity");

    a_fail_hnd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> handle_out == ZERO_H)
        else $error("handle on failed item");

endmodule

bind indexed_min_heap_queue imq_port_checks u_imq_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .status     (res.status),
    .handle_out (res.handle_out),
    .count      (res.count)
);
